// File: src/swm_pkg.sv
// Shared types and constants for the sliding window mean unit.
`default_nettype none

package swm_pkg;

  // Width of the window length register and of the fill count result.
  localparam int WIN_REG_BITS = 9;
  localparam logic [WIN_REG_BITS-1:0] WINDOW_RESET = 9'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_HOLD
  } swm_state_t;

endpackage

`default_nettype wire

// File: src/swm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/swm_div.sv
// Radix-2 restoring divider: signed dividend over unsigned divisor, truncates toward zero.
`default_nettype none

module swm_div #(
  parameter int DIVIDEND_BITS = 33,
  parameter int DIVISOR_BITS  = 9
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [DIVIDEND_BITS-1:0] dividend,
  input  wire logic        [DIVISOR_BITS-1:0]  divisor,
  output logic                                 done,
  output logic signed      [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [CNT_BITS-1:0]      count;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvsr;
  logic                     neg;

  logic [DIVISOR_BITS:0]    rem_shift;
  logic                     fits;
  logic [DIVISOR_BITS:0]    rem_diff;

  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_BITS-1]};
    fits      = rem_shift >= {1'b0, dvsr};
    rem_diff  = rem_shift - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_BITS'(DIVIDEND_BITS);
      end else if (count != '0) begin
        count <= count - 1'b1;
        done  <= (count == CNT_BITS'(1));
      end
    end
  end

  // Datapath: magnitude in, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DIVIDEND_BITS-1];
      quo  <= dividend[DIVIDEND_BITS-1] ? -dividend : dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (count != '0) begin
      rem <= fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
      quo <= {quo[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign quotient = neg ? -signed'(quo) : signed'(quo);

endmodule

`default_nettype wire

// File: src/sliding_window_mean_unit.sv
// Top level of the boxcar moving average: sample ring, running sum and mean divider.
`default_nettype none

// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  -------------------------------------
// in        in   in_valid / in_stall    sample [SAMPLE_BITS] signed
// out       out  out_valid / out_stall  window_mean [SAMPLE_BITS] signed,
//                                       fill_count [9]
// cfg       in   cfg_valid / cfg_ready  window_length [9]
//
// Sequence: a request passes through ring read, sum update and ring write,
//   divider load and SUM_BITS radix-2 divider steps, after which the quotient
//   is ready.
//   The divider sets the rate; the output register frees the core right away.
// Reset: synchronous, clears ring pointer, fill count and sum, window goes to 16.
//   The ring RAM is not cleared; read data is used only once its entry was written.
// Stalls: a result waits in the output register while the next request is taken;
//   a finished quotient waits in the divider if that register is still full.

module sliding_window_mean_unit
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // sample requests
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  // results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [SAMPLE_BITS-1:0] window_mean,
  output logic             [WIN_REG_BITS-1:0] fill_count,
  // window register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic        [WIN_REG_BITS-1:0] window_length
);

  localparam int SLOT_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int COUNT_BITS = $clog2(MAX_WINDOW + 1);
  // Sum of up to MAX_WINDOW samples never overflows this width.
  localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;

  swm_state_t state, state_next;

  logic [WIN_REG_BITS-1:0]    win_reg;
  logic [COUNT_BITS-1:0]      win_eff;
  logic [SLOT_BITS-1:0]       write_slot;
  logic [COUNT_BITS-1:0]      held_count;
  logic signed [SUM_BITS-1:0] running_sum;

  // Request being worked on
  logic [SLOT_BITS-1:0]         cur_slot;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic                         cur_evict;

  logic                   in_take;
  logic                   cfg_take;
  logic                   out_free;
  logic [SLOT_BITS-1:0]   slot_sel;
  logic [COUNT_BITS:0]    slot_inc;

  logic                   ram_rd_en;
  logic                   ram_wr_en;
  logic [SAMPLE_BITS-1:0] ram_rd_data;

  logic signed [SUM_BITS-1:0] evicted;
  logic signed [SUM_BITS-1:0] sum_next;
  logic [COUNT_BITS-1:0]      held_next;

  logic                       div_start;
  logic                       div_done;
  logic signed [SUM_BITS-1:0] div_quot;
  logic                       out_load;

  // Window zero acts as one, anything above MAX_WINDOW saturates.
  always_comb begin
    if (win_reg == '0) begin
      win_eff = COUNT_BITS'(1);
    end else if (32'(win_reg) > 32'(MAX_WINDOW)) begin
      win_eff = COUNT_BITS'(MAX_WINDOW);
    end else begin
      win_eff = COUNT_BITS'(win_reg);
    end
  end

  // Config wins a tie so the ring is never emptied under a running request.
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Slot to write; wraps if the window shrank below the pointer.
  assign slot_sel = (COUNT_BITS'(write_slot) >= win_eff) ? '0 : write_slot;
  assign slot_inc = (COUNT_BITS + 1)'(cur_slot) + 1'b1;

  // Read-modify-write of the ring. The FSM is the interlock: the next read is
  // issued only after the previous write has landed.
  always_comb begin
    evicted   = cur_evict ? SUM_BITS'(signed'(ram_rd_data)) : '0;
    sum_next  = running_sum - evicted + SUM_BITS'(cur_sample);
    held_next = cur_evict ? win_eff : held_count + 1'b1;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_take) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_START;
      ST_START:  state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   ram_rd_en = in_take;
      ST_UPDATE: ram_wr_en = 1'b1;
      ST_START:  div_start = 1'b1;
      ST_DIVIDE: out_load  = div_done && out_free;
      ST_HOLD:   out_load  = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      win_reg     <= WINDOW_RESET;
      write_slot  <= '0;
      held_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_take) begin
        win_reg     <= window_length;
        write_slot  <= '0;
        held_count  <= '0;
        running_sum <= '0;
      end else if (ram_wr_en) begin
        running_sum <= sum_next;
        held_count  <= held_next;
        write_slot  <= (slot_inc >= (COUNT_BITS + 1)'(win_eff)) ? '0 : slot_inc[SLOT_BITS-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_slot   <= slot_sel;
      cur_sample <= sample;
      cur_evict  <= held_count >= win_eff;
    end
    if (out_load) begin
      window_mean <= div_quot[SAMPLE_BITS-1:0];
      fill_count  <= WIN_REG_BITS'(held_count);
    end
  end

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cur_slot),
    .wr_data (cur_sample),
    .rd_en   (ram_rd_en),
    .rd_addr (slot_sel),
    .rd_data (ram_rd_data)
  );

  swm_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (held_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Checks
  assert property (@(posedge clk) disable iff (rst) held_count <= win_eff)
    else $error("fill count above window");

  assert property (@(posedge clk) disable iff (rst) COUNT_BITS'(write_slot) < win_eff)
    else $error("ring pointer outside window");

  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside divide phase");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> fill_count != '0)
    else $error("result with empty window");

endmodule

`default_nettype wire
